// ----- sv/pqs_pkg.sv -----
// shared types and constants for the process queue with statistics
// holds queue sizing, command and result structs, codes and the sequencer states
// no dependencies
package pqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 16;

    // action codes
    localparam logic [1:0] ACT_ENQ = 2'd0;
    localparam logic [1:0] ACT_DEQ = 2'd1;
    localparam logic [1:0] ACT_QRY = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ID_W-1:0]   process_id;
        logic [TIME_W-1:0] exec_time;
    } t_pq_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   out_id;
        logic [TIME_W-1:0] out_time;
        logic [CNT_W-1:0]  match_count;
        logic [ID_W-1:0]   min_time_id;
        logic [ID_W-1:0]   max_time_id;
        logic [CNT_W-1:0]  occupancy;
    } t_pq_out;

    // one stored queue entry
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] etime;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

endpackage

// ----- sv/pqs_ram.sv -----
// simple dual-port synchronous ram, one write port and one read port
// read data is registered
// no dependencies
module pqs_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/process_queue_with_stats_top.sv -----
// top level of the process queue with statistics
// sequencer and scan datapath around one entry ram
// depends on pqs_pkg and pqs_ram
//
// A bounded fifo of up to QUEUE_DEPTH process entries (16-bit id, 16-bit time),
// kept in one synchronous ram with registered read data. A transaction is taken
// when start is high and busy is low; exactly one result follows, shown on
// o_result while o_done is high for one cycle, and the receiver cannot stall it.
// Enqueue and query walk the held entries one ram read per cycle in the scan
// state and then pass to the finish state; dequeue and the unused action code
// go from accept straight to the finish state, skipping the scan. The result
// strobe comes in the first cycle in which busy is low again, so a new
// transaction may be started in that same cycle.
module process_queue_with_stats_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  pqs_pkg::t_pq_in  i_cmd,
    output logic            o_done,
    output pqs_pkg::t_pq_out o_result
);

    import pqs_pkg::*;

    // sequencer and queue pointers
    t_state            r_state, n_state;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [PTR_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;

    // latched transaction
    t_pq_in            r_cmd, n_cmd;

    // scan bookkeeping: issued reads and a pending read in flight
    logic [CNT_W-1:0]  r_iss, n_iss;
    logic              r_pend, n_pend;
    logic              r_first, n_first;

    // scan accumulators
    logic              r_dup, n_dup;
    logic [CNT_W-1:0]  r_match, n_match;
    logic [TIME_W-1:0] r_min_t, n_min_t;
    logic [TIME_W-1:0] r_max_t, n_max_t;
    logic [ID_W-1:0]   r_min_id, n_min_id;
    logic [ID_W-1:0]   r_max_id, n_max_id;

    // result register
    t_pq_out           r_res, n_res;
    logic              r_done, n_done;

    // ram port
    logic              ram_we;
    logic [PTR_W-1:0]  ram_waddr;
    t_entry            ram_wdata;
    logic [PTR_W-1:0]  ram_raddr;
    t_entry            ram_rdata;

    // slot of the entry head + iss, wrapped into the ring
    logic [PTR_W:0]    scan_sum;
    logic [PTR_W-1:0]  scan_addr;

    assign scan_sum  = {1'b0, r_head} + (PTR_W+1)'(r_iss);
    assign scan_addr = (scan_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                     ? PTR_W'(scan_sum - (PTR_W+1)'(QUEUE_DEPTH))
                     : PTR_W'(scan_sum);

    pqs_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH ($bits(t_entry))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_done  <= n_done;
            r_pend  <= n_pend;
        end
    end

    // payload and scan datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_iss    <= n_iss;
        r_first  <= n_first;
        r_dup    <= n_dup;
        r_match  <= n_match;
        r_min_t  <= n_min_t;
        r_max_t  <= n_max_t;
        r_min_id <= n_min_id;
        r_max_id <= n_max_id;
        r_res    <= n_res;
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_iss     = r_iss;
        n_pend    = 1'b0;
        n_first   = r_first;
        n_dup     = r_dup;
        n_match   = r_match;
        n_min_t   = r_min_t;
        n_max_t   = r_max_t;
        n_min_id  = r_min_id;
        n_max_id  = r_max_id;
        n_res     = r_res;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_tail;
        ram_wdata = '{id: r_cmd.process_id, etime: r_cmd.exec_time};
        ram_raddr = r_head;

        unique case (r_state)
            S_IDLE: begin
                // head is read here so a dequeue finds its entry in the next cycle
                if (start) begin
                    n_cmd   = i_cmd;
                    n_iss   = '0;
                    n_first = 1'b1;
                    n_dup   = 1'b0;
                    n_match = '0;
                    if (i_cmd.action == ACT_ENQ || i_cmd.action == ACT_QRY) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end

            S_SCAN: begin
                ram_raddr = scan_addr;
                // fold in the entry read in the previous cycle
                if (r_pend) begin
                    if (ram_rdata.id == r_cmd.process_id) begin
                        n_dup = 1'b1;
                    end
                    if (ram_rdata.etime == r_cmd.exec_time) begin
                        n_match = CNT_W'(r_match + 1'b1);
                    end
                    // strict compares keep the oldest entry on ties
                    if (r_first) begin
                        n_first  = 1'b0;
                        n_min_t  = ram_rdata.etime;
                        n_max_t  = ram_rdata.etime;
                        n_min_id = ram_rdata.id;
                        n_max_id = ram_rdata.id;
                    end else begin
                        if (ram_rdata.etime < r_min_t) begin
                            n_min_t  = ram_rdata.etime;
                            n_min_id = ram_rdata.id;
                        end
                        if (ram_rdata.etime > r_max_t) begin
                            n_max_t  = ram_rdata.etime;
                            n_max_id = ram_rdata.id;
                        end
                    end
                end
                // issue the next read, or stop once every held entry is out
                if (r_iss == r_count) begin
                    n_state = S_FIN;
                end else begin
                    n_iss  = CNT_W'(r_iss + 1'b1);
                    n_pend = 1'b1;
                end
            end

            S_FIN: begin
                n_res  = '0;
                n_done = 1'b1;
                n_state = S_IDLE;
                unique case (r_cmd.action)
                    ACT_ENQ: begin
                        priority if (r_dup) begin
                            n_res.status = ST_DUP;
                        end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_res.status = ST_FULL;
                        end else begin
                            ram_we  = 1'b1;
                            n_tail  = (r_tail == PTR_W'(QUEUE_DEPTH - 1))
                                    ? '0 : PTR_W'(r_tail + 1'b1);
                            n_count = CNT_W'(r_count + 1'b1);
                        end
                    end
                    ACT_DEQ: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_res.out_id   = ram_rdata.id;
                            n_res.out_time = ram_rdata.etime;
                            n_head  = (r_head == PTR_W'(QUEUE_DEPTH - 1))
                                    ? '0 : PTR_W'(r_head + 1'b1);
                            n_count = CNT_W'(r_count - 1'b1);
                        end
                    end
                    ACT_QRY: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_res.match_count = r_match;
                            n_res.min_time_id = r_min_id;
                            n_res.max_time_id = r_max_id;
                        end
                    end
                    default: begin
                        // unused action code: nothing changes
                        n_res.status = ST_OK;
                    end
                endcase
                n_res.occupancy = n_count;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
